>>> rtl/utf8_decoder_with_replacement_macros.svh
// Assertion helpers used by the decoder RTL.
`ifndef UTF8_DECODER_WITH_REPLACEMENT_MACROS_SVH
`define UTF8_DECODER_WITH_REPLACEMENT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define U8D_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define U8D_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/u8dec_pkg.sv
package u8dec_pkg;

    localparam int unsigned CP_W      = 21;
    localparam int unsigned MAX_RES   = 4;
    localparam int unsigned RES_IDX_W = $clog2(MAX_RES);
    localparam int unsigned RES_CNT_W = $clog2(MAX_RES + 1);

    localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00FFFD;
    localparam logic [CP_W-1:0] CP_MAX         = 21'h10FFFF;
    localparam logic [CP_W-1:0] CP_SURR_LO     = 21'h00D800;
    localparam logic [CP_W-1:0] CP_SURR_HI     = 21'h00DFFF;
    localparam logic [CP_W-1:0] CP_MIN_2B      = 21'h000080;
    localparam logic [CP_W-1:0] CP_MIN_3B      = 21'h000800;
    localparam logic [CP_W-1:0] CP_MIN_4B      = 21'h010000;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            repl;
    } t_result;

endpackage

>>> rtl/utf8_decoder_with_replacement.sv
// UTF-8 decoder with U+FFFD replacement.
// Input stream: s_axis_tdata carries one text byte, s_axis_tlast marks the last
// byte of the text. Output stream: m_axis_tdata carries a 21-bit code point,
// m_axis_tuser flags a replacement, m_axis_tlast marks the final code point that
// one input byte produced. A byte may produce zero to four code points.
// A byte's code points are registered first in the result group and then in
// the output register before they are presented. Throughput: one byte per cycle
// while every byte yields at most one code point and the receiver does not
// stall; a byte yielding several code points holds off the next byte until the
// single output register takes the last entry of the per-byte result group.
// The input is taken whenever the result group is empty or hands over its last
// entry in that cycle, so a byte is still taken while a code point waits in the
// output register under backpressure.
// Reset (synchronous, active low) drops any pending sequence and any buffered
// results; ready stays low during reset and is high in the first cycle after it.
// When the receiver stalls, the output holds, the group fills and the input
// then deasserts ready until the group drains.
`include "utf8_decoder_with_replacement_macros.svh"

module utf8_decoder_with_replacement (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
    input  logic        s_axis_tlast,   // end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] zero
    output logic        m_axis_tuser,   // [0] replaced
    output logic        m_axis_tlast    // run_last
);

    localparam int unsigned CW = u8dec_pkg::CP_W;
    localparam int unsigned NR = u8dec_pkg::MAX_RES;
    localparam int unsigned IW = u8dec_pkg::RES_IDX_W;
    localparam int unsigned KW = u8dec_pkg::RES_CNT_W;

    // decoder state
    logic [7:0]  r_lead;
    logic [1:0]  r_need;
    logic [7:0]  r_held [2];
    logic [1:0]  r_held_cnt;
    logic [7:0]  n_lead;
    logic [1:0]  n_need;
    logic [7:0]  n_held [2];
    logic [1:0]  n_held_cnt;

    // result group of the last accepted byte
    u8dec_pkg::t_result r_grp [NR];
    logic [IW-1:0]      r_grp_head;
    logic [KW-1:0]      r_grp_left;

    // output register
    logic          r_out_valid;
    logic [CW-1:0] r_out_cp;
    logic          r_out_repl;
    logic          r_out_last;

    u8dec_pkg::t_result d_res [NR];
    logic [KW-1:0]      d_cnt;

    logic w_accept;
    logic w_move;

    // combinational decode of one byte against the pending sequence
    logic [7:0]    d_buf [4];
    logic [2:0]    d_n;
    logic [2:0]    d_pos;
    logic          d_done;
    logic [7:0]    d_b;
    logic [7:0]    d_c;
    logic [2:0]    d_k;
    logic [CW-1:0] d_cp;
    logic [CW-1:0] d_min;
    logic [2:0]    d_bad;
    logic [2:0]    d_idx;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            d_buf[i] = s_axis_tdata;
        end
        d_n = 3'd0;
        if (r_need != 2'd0) begin
            d_buf[0] = r_lead;
            d_buf[1] = r_held[0];
            d_buf[2] = r_held[1];
            d_n      = 3'd1 + {1'b0, r_held_cnt};
        end
        d_buf[d_n[1:0]] = s_axis_tdata;
        d_n = d_n + 3'd1;

        n_lead     = 8'd0;
        n_need     = 2'd0;
        n_held     = r_held;
        n_held_cnt = 2'd0;
        for (int i = 0; i < NR; i++) begin
            d_res[i].cp   = u8dec_pkg::CP_REPLACEMENT;
            d_res[i].repl = 1'b1;
        end
        d_cnt  = '0;
        d_pos  = 3'd0;
        d_done = 1'b0;
        d_b    = 8'd0;
        d_c    = 8'd0;
        d_k    = 3'd0;
        d_cp   = '0;
        d_min  = '0;
        d_bad  = 3'd0;
        d_idx  = 3'd0;

        // every pass consumes at least one byte, so four passes cover the buffer
        for (int it = 0; it < 4; it++) begin
            if (!d_done && d_pos < d_n) begin
                d_b = d_buf[d_pos[1:0]];
                d_k = 3'd0;
                if ((d_b & 8'hE0) == 8'hC0) begin
                    d_k = 3'd1; d_cp = CW'(d_b & 8'h1F); d_min = u8dec_pkg::CP_MIN_2B;
                end else if ((d_b & 8'hF0) == 8'hE0) begin
                    d_k = 3'd2; d_cp = CW'(d_b & 8'h0F); d_min = u8dec_pkg::CP_MIN_3B;
                end else if ((d_b & 8'hF8) == 8'hF0) begin
                    d_k = 3'd3; d_cp = CW'(d_b & 8'h07); d_min = u8dec_pkg::CP_MIN_4B;
                end

                if (d_b[7] == 1'b0) begin
                    d_res[d_cnt[IW-1:0]].cp   = CW'(d_b);
                    d_res[d_cnt[IW-1:0]].repl = 1'b0;
                    d_cnt = d_cnt + KW'(1);
                    d_pos = d_pos + 3'd1;
                end else if (d_k == 3'd0) begin
                    // byte that cannot start a sequence
                    d_cnt = d_cnt + KW'(1);
                    d_pos = d_pos + 3'd1;
                end else if ({1'b0, d_pos} + 4'd1 + {1'b0, d_k} > {1'b0, d_n}) begin
                    // not enough bytes yet
                    d_done = 1'b1;
                    if (s_axis_tlast) begin
                        d_cnt = d_cnt + KW'(1);
                    end else begin
                        n_lead     = d_b;
                        n_need     = d_k[1:0];
                        n_held_cnt = 2'(d_n - d_pos - 3'd1);
                        d_idx      = d_pos + 3'd1;
                        n_held[0]  = d_buf[d_idx[1:0]];
                        d_idx      = d_pos + 3'd2;
                        n_held[1]  = d_buf[d_idx[1:0]];
                    end
                end else begin
                    d_bad = 3'd0;
                    for (int j = 1; j <= 3; j++) begin
                        if (3'(j) <= d_k && d_bad == 3'd0) begin
                            d_idx = d_pos + 3'(j);
                            d_c   = d_buf[d_idx[1:0]];
                            if (d_c[7:6] != 2'b10) begin
                                d_bad = 3'(j);
                            end else begin
                                d_cp = {d_cp[CW-7:0], d_c[5:0]};
                            end
                        end
                    end
                    if (d_bad != 3'd0) begin
                        // resume at the offending byte as a new lead
                        d_cnt = d_cnt + KW'(1);
                        d_pos = d_pos + d_bad;
                    end else begin
                        d_pos = d_pos + 3'd1 + d_k;
                        if (!(d_cp < d_min || d_cp > u8dec_pkg::CP_MAX ||
                              (d_cp >= u8dec_pkg::CP_SURR_LO &&
                               d_cp <= u8dec_pkg::CP_SURR_HI))) begin
                            d_res[d_cnt[IW-1:0]].cp   = d_cp;
                            d_res[d_cnt[IW-1:0]].repl = 1'b0;
                        end
                        d_cnt = d_cnt + KW'(1);
                    end
                end
            end
        end
    end

    assign w_move        = (r_grp_left != '0) && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = i_rst_n &&
                           ((r_grp_left == '0) || (r_grp_left == KW'(1) && w_move));
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead     <= 8'd0;
            r_need     <= 2'd0;
            r_held_cnt <= 2'd0;
        end else if (w_accept) begin
            r_lead     <= n_lead;
            r_need     <= n_need;
            r_held_cnt <= n_held_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_held <= n_held;
            r_grp  <= d_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp_head <= '0;
            r_grp_left <= '0;
        end else if (w_accept) begin
            r_grp_head <= '0;
            r_grp_left <= d_cnt;
        end else if (w_move) begin
            r_grp_head <= r_grp_head + IW'(1);
            r_grp_left <= r_grp_left - KW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out_cp   <= r_grp[r_grp_head].cp;
            r_out_repl <= r_grp[r_grp_head].repl;
            r_out_last <= (r_grp_left == KW'(1));
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(24 - CW){1'b0}}, r_out_cp};
    assign m_axis_tuser  = r_out_repl;
    assign m_axis_tlast  = r_out_last;

    `U8D_ASSERT_NOW(a_accept_group_free, w_accept,
        (r_grp_left == '0) || w_move, "byte taken while result group busy")
    `U8D_ASSERT_NOW(a_held_within_need, r_need != 2'd0,
        r_held_cnt < r_need, "held byte count not below needed count")
    `U8D_ASSERT_NOW(a_idle_no_held, r_need == 2'd0,
        r_held_cnt == 2'd0, "held bytes without a pending lead")
    `U8D_ASSERT_NEXT(a_eot_clears, w_accept && s_axis_tlast,
        r_need == 2'd0, "sequence left pending after end of text")
    `U8D_ASSERT_NEXT(a_last_on_final, w_move,
        m_axis_tlast == ($past(r_grp_left) == KW'(1)), "tlast not on final code point")

endmodule
